// ----- design/pnes_pkg.sv -----
// Shared types and constants for the pattern note event scheduler.
package pnes_pkg;

  localparam int unsigned MAX_EVENTS = 64;
  localparam logic [7:0] ANY_TARGET = 8'd255;

  typedef enum logic [1:0] {
    KIND_ON   = 2'd0,
    KIND_OFF  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_PATTERN_LEN = 2'd0,
    REG_SPT         = 2'd1,
    REG_NOTE_COUNT  = 2'd2
  } reg_idx_t;

  typedef enum logic [0:0] {
    REQ_NOTE_WRITE = 1'b0,
    REQ_BLOCK      = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SPAN,
    ST_CHECK,
    ST_MUL,
    ST_CLAMP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [15:0] tick;
    logic [15:0] dur;
    logic [6:0]  pitch;
    logic [6:0]  vel;
    logic        muted;
    logic [7:0]  target;
  } note_t;

endpackage

// ----- design/pnes_mod_unit.sv -----
// Restoring remainder unit, one quotient bit per cycle.
module pnes_mod_unit import pnes_pkg::*; #(
  parameter int LW = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [31:0]   dividend,
  input  logic [LW-1:0] divisor,
  output logic          done,
  output logic [LW-1:0] remainder
);

  logic [31:0]   dvd_r;
  logic [LW-1:0] div_r, rem_r;
  logic [5:0]    cnt_r;
  logic          run_r;
  logic [LW:0]   rem_sh;

  assign rem_sh = {rem_r, dvd_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        dvd_r <= dividend;
        div_r <= divisor;
        rem_r <= '0;
      end else if (run_r) begin
        dvd_r <= {dvd_r[30:0], 1'b0};
        if (rem_sh >= {1'b0, div_r}) rem_r <= LW'(rem_sh - {1'b0, div_r});
        else rem_r <= LW'(rem_sh);
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem_r;

endmodule

// ----- design/pnes_note_table.sv -----
// Note table memory, one write and one registered read port.
module pnes_note_table import pnes_pkg::*; #(
  parameter int NOTES = 16,
  parameter int KW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [KW-1:0] waddr,
  input  note_t         wdata,
  input  logic [KW-1:0] raddr,
  output note_t         rdata
);

  note_t mem [NOTES];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- design/pnes_offset_unit.sv -----
// Sample offset: registered delta times rate product, then clamp to the block.
module pnes_offset_unit import pnes_pkg::*; #(
  parameter int TFB = 8,
  parameter int FW  = 13
) (
  input  logic          clk,
  input  logic [31:0]   delta,
  input  logic [31:0]   spt,
  input  logic [FW-1:0] frames,
  output logic [11:0]   offset
);

  localparam int SW = 64 - TFB - 16;

  logic [63:0]   prod_r;
  logic [SW-1:0] s;
  logic [FW-1:0] fmax;

  always_ff @(posedge clk) prod_r <= delta * spt;

  always_comb begin
    s    = prod_r[63:TFB+16];
    fmax = frames - FW'(1);
    if (s > SW'(fmax)) offset = fmax[11:0];
    else offset = s[11:0];
  end

endmodule

// ----- design/pattern_note_event_scheduler_unit.sv -----
// Top level of the pattern note event scheduler.
// A block request first runs the remainder iteration, then walks the note
// table once per span (at most two spans): a setup state, one check per note
// edge (two per note), plus the shared multiply and clamp states for each
// event emitted, then a flush state; a request that has nothing to emit up
// front goes straight to the flush state. busy stays high for the whole
// request. Results appear on out_valid for one cycle each and cannot be
// stalled; out_last marks the final one, which shows in the same cycle that
// busy drops.
module pattern_note_event_scheduler_unit import pnes_pkg::*; #(
  parameter int NOTES          = 16,
  parameter int TICK_FRAC_BITS = 8,
  parameter int MAX_FRAMES     = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [3:0]  in_note_index,
  input  logic [15:0] in_note_tick,
  input  logic [15:0] in_note_duration,
  input  logic [6:0]  in_note_number,
  input  logic [6:0]  in_note_velocity,
  input  logic        in_note_muted,
  input  logic [7:0]  in_note_target,
  input  logic [31:0] in_tick_start,
  input  logic [31:0] in_tick_end,
  input  logic [7:0]  in_channel_id,
  input  logic [12:0] in_block_frames,
  output logic        out_valid,
  output logic [1:0]  out_event_kind,
  output logic [6:0]  out_event_note,
  output logic [6:0]  out_event_velocity,
  output logic [11:0] out_sample_offset,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int KW  = (NOTES > 1) ? $clog2(NOTES) : 1;
  localparam int CW  = $clog2(NOTES + 1);
  localparam int LW  = 17 + TICK_FRAC_BITS;
  localparam int PW  = (LW > 32) ? LW : 32;
  localparam int MFW = $clog2(MAX_FRAMES + 1);
  localparam int FW  = (MFW > 13) ? MFW : 13;

  logic [15:0] plen_r;
  logic [31:0] spt_r;
  logic [4:0]  ncount_r;

  state_t state_r, state_nxt;

  logic [31:0]   remaining_r, remaining_nxt;
  logic [PW-1:0] pos_r, pos_nxt, base_r, base_nxt;
  logic [PW-1:0] span_r, span_nxt, spanend_r, spanend_nxt;
  logic [7:0]    chan_r;
  logic [FW-1:0] frames_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] k_r, k_nxt;
  logic          ph_r, ph_nxt, sp_r, sp_nxt;
  logic [6:0]    evcnt_r, evcnt_nxt;
  logic [31:0]   delta_r, delta_nxt;
  logic [1:0]    ckind_r, ckind_nxt;
  logic [6:0]    cpitch_r, cpitch_nxt, cvel_r, cvel_nxt;
  logic          have_r, have_nxt;
  logic [1:0]    hkind_r, hkind_nxt;
  logic [6:0]    hpitch_r, hpitch_nxt, hvel_r, hvel_nxt;
  logic [11:0]   hoff_r, hoff_nxt;
  logic          ov_nxt, olast_nxt;
  logic [1:0]    okind_nxt;
  logic [6:0]    onote_nxt, ovel_nxt;
  logic [11:0]   ooff_nxt;

  logic          accept, cfg_we, mod_go, mod_done, tbl_we;
  logic [LW-1:0] lenq, mod_rem;
  logic [PW-1:0] lenq_p, avail, on_pos, off_pos, val, span_c;
  logic [31:0]   rem_after;
  logic [FW-1:0] frames_in;
  logic [CW-1:0] count_in;
  logic          elig, hit, last_edge, empty_req;
  logic [11:0]   offset;
  note_t         wnote, rnote;

  assign pready = 1'b1;
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign cfg_we = psel && penable && pwrite && pready;
  assign tbl_we = accept && (in_req_type == REQ_NOTE_WRITE) &&
                  (32'(in_note_index) < 32'(NOTES));
  assign lenq   = LW'(plen_r) << TICK_FRAC_BITS;
  assign lenq_p = PW'(lenq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r   <= 16'd384;
      spt_r    <= 32'd65536;
      ncount_r <= 5'd0;
    end else if (cfg_we) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_PATTERN_LEN: plen_r   <= pwdata[15:0];
        REG_SPT:         spt_r    <= pwdata;
        REG_NOTE_COUNT:  ncount_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_PATTERN_LEN: prdata = {16'd0, plen_r};
      REG_SPT:         prdata = spt_r;
      REG_NOTE_COUNT:  prdata = {27'd0, ncount_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign wnote = '{tick: in_note_tick, dur: in_note_duration, pitch: in_note_number,
                   vel: in_note_velocity, muted: in_note_muted, target: in_note_target};

  pnes_note_table #(.NOTES(NOTES), .KW(KW)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (KW'(in_note_index)),
    .wdata (wnote),
    .raddr (k_nxt[KW-1:0]),
    .rdata (rnote)
  );

  pnes_mod_unit #(.LW(LW)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (mod_go),
    .dividend  (in_tick_start),
    .divisor   (lenq),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  pnes_offset_unit #(.TFB(TICK_FRAC_BITS), .FW(FW)) u_off (
    .clk    (clk),
    .delta  (delta_r),
    .spt    (spt_r),
    .frames (frames_r),
    .offset (offset)
  );

  always_comb begin
    frames_in = (32'(in_block_frames) > 32'(MAX_FRAMES)) ? FW'(MAX_FRAMES)
                                                         : FW'(in_block_frames);
    count_in  = (32'(ncount_r) > 32'(NOTES)) ? CW'(NOTES) : CW'(ncount_r);
    empty_req = (plen_r == 16'd0) || (spt_r == 32'd0) || (frames_in == '0) ||
                (count_in == '0) || (in_tick_end <= in_tick_start);
    avail     = lenq_p - pos_r;
    span_c    = (PW'(remaining_r) < avail) ? PW'(remaining_r) : avail;
    rem_after = remaining_r - span_r[31:0];
    on_pos    = PW'(rnote.tick) << TICK_FRAC_BITS;
    off_pos   = PW'({1'b0, rnote.tick} + {1'b0, rnote.dur}) << TICK_FRAC_BITS;
    val       = ph_r ? off_pos : on_pos;
    elig      = !rnote.muted && (rnote.target == ANY_TARGET || rnote.target == chan_r);
    hit       = elig && (val >= pos_r) && (val < spanend_r) &&
                (32'(evcnt_r) < MAX_EVENTS);
    last_edge = ph_r && (k_r == count_r - CW'(1));
  end

  always_comb begin
    state_nxt     = state_r;
    remaining_nxt = remaining_r;
    pos_nxt       = pos_r;
    base_nxt      = base_r;
    span_nxt      = span_r;
    spanend_nxt   = spanend_r;
    k_nxt         = k_r;
    ph_nxt        = ph_r;
    sp_nxt        = sp_r;
    evcnt_nxt     = evcnt_r;
    delta_nxt     = delta_r;
    ckind_nxt     = ckind_r;
    cpitch_nxt    = cpitch_r;
    cvel_nxt      = cvel_r;
    have_nxt      = have_r;
    hkind_nxt     = hkind_r;
    hpitch_nxt    = hpitch_r;
    hvel_nxt      = hvel_r;
    hoff_nxt      = hoff_r;
    ov_nxt        = 1'b0;
    olast_nxt     = 1'b0;
    okind_nxt     = hkind_r;
    onote_nxt     = hpitch_r;
    ovel_nxt      = hvel_r;
    ooff_nxt      = hoff_r;
    mod_go        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_req_type == REQ_BLOCK) begin
          have_nxt      = 1'b0;
          evcnt_nxt     = '0;
          sp_nxt        = 1'b0;
          base_nxt      = '0;
          remaining_nxt = in_tick_end - in_tick_start;
          if (empty_req) begin
            state_nxt = ST_FLUSH;
          end else begin
            mod_go    = 1'b1;
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          pos_nxt   = PW'(mod_rem);
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        span_nxt    = span_c;
        spanend_nxt = pos_r + span_c;
        k_nxt       = '0;
        ph_nxt      = 1'b0;
        state_nxt   = ST_CHECK;
      end
      ST_CHECK, ST_CLAMP: begin
        if (state_r == ST_CHECK && hit) begin
          delta_nxt  = 32'(base_r + (val - pos_r));
          ckind_nxt  = ph_r ? KIND_OFF : KIND_ON;
          cpitch_nxt = rnote.pitch;
          cvel_nxt   = ph_r ? 7'd0 : rnote.vel;
          state_nxt  = ST_MUL;
        end else begin
          if (state_r == ST_CLAMP) begin
            if (have_r) ov_nxt = 1'b1;
            have_nxt   = 1'b1;
            hkind_nxt  = ckind_r;
            hpitch_nxt = cpitch_r;
            hvel_nxt   = cvel_r;
            hoff_nxt   = offset;
            evcnt_nxt  = evcnt_r + 7'd1;
          end
          state_nxt = ST_CHECK;
          if (!ph_r) begin
            ph_nxt = 1'b1;
          end else begin
            ph_nxt = 1'b0;
            k_nxt  = k_r + CW'(1);
          end
          if (last_edge) begin
            k_nxt         = '0;
            base_nxt      = base_r + span_r;
            remaining_nxt = rem_after;
            pos_nxt       = '0;
            sp_nxt        = 1'b1;
            if (!sp_r && rem_after != 32'd0) state_nxt = ST_SPAN;
            else state_nxt = ST_FLUSH;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_CLAMP;
      end
      ST_FLUSH: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        if (!have_r) begin
          okind_nxt = KIND_DONE;
          onote_nxt = '0;
          ovel_nxt  = '0;
          ooff_nxt  = '0;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
      have_r    <= 1'b0;
      k_r       <= '0;
      ph_r      <= 1'b0;
      sp_r      <= 1'b0;
      evcnt_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= ov_nxt;
      have_r    <= have_nxt;
      k_r       <= k_nxt;
      ph_r      <= ph_nxt;
      sp_r      <= sp_nxt;
      evcnt_r   <= evcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remaining_r <= remaining_nxt;
    pos_r       <= pos_nxt;
    base_r      <= base_nxt;
    span_r      <= span_nxt;
    spanend_r   <= spanend_nxt;
    delta_r     <= delta_nxt;
    ckind_r     <= ckind_nxt;
    cpitch_r    <= cpitch_nxt;
    cvel_r      <= cvel_nxt;
    hkind_r     <= hkind_nxt;
    hpitch_r    <= hpitch_nxt;
    hvel_r      <= hvel_nxt;
    hoff_r      <= hoff_nxt;
    out_last           <= olast_nxt;
    out_event_kind     <= okind_nxt;
    out_event_note     <= onote_nxt;
    out_event_velocity <= ovel_nxt;
    out_sample_offset  <= ooff_nxt;
    if (accept && in_req_type == REQ_BLOCK) begin
      chan_r   <= in_channel_id;
      frames_r <= frames_in;
      count_r  <= count_in;
    end
  end

endmodule

// ----- design/pnes_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
module pnes_checker import pnes_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_req_type,
  input logic        out_valid,
  input logic [1:0]  out_event_kind,
  input logic [6:0]  out_event_velocity,
  input logic        out_last
);

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("last result while busy");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == REQ_NOTE_WRITE |=> !out_valid && !busy)
    else $error("note write produced output");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == KIND_DONE |-> out_last)
    else $error("done marker not last");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_kind == KIND_ON || out_event_kind == KIND_OFF ||
                  out_event_kind == KIND_DONE) else $error("bad event kind");

  a_off_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == KIND_OFF |-> out_event_velocity == 7'd0)
    else $error("note off with velocity");

endmodule

bind pattern_note_event_scheduler_unit pnes_checker u_pnes_checker (.*);
